[rtl/rpts_pkg.sv]
// Shared types and constants for the priority task scheduler coprocessor.
// Depends on nothing; used by the scan unit, the scheduler top level and the testbench.
`timescale 1ns / 1ps
package rpts_pkg;

	// Command codes carried by the opcode field.
	typedef enum logic [3:0] {
		OP_CREATE     = 4'd0,
		OP_START      = 4'd1,
		OP_DELAY      = 4'd2,
		OP_TICK       = 4'd3,
		OP_ISR_ENTER  = 4'd4,
		OP_ISR_EXIT   = 4'd5,
		OP_SEM_CREATE = 4'd6,
		OP_PEND       = 4'd7,
		OP_POST       = 4'd8
	} opcode_t;

	// Task status codes.
	typedef enum logic [1:0] {
		ST_READY     = 2'd0,
		ST_DELAYED   = 2'd1,
		ST_SUSPENDED = 2'd2
	} status_t;

	localparam logic [6:0] PRIO_NONE = 7'd100;
	localparam logic [6:0] PRIO_IDLE = 7'd99;
	localparam logic signed [15:0] SEM_MAX = 16'sh7fff;
	localparam logic signed [15:0] SEM_MIN = -16'sh8000;

endpackage

[rtl/rpts_scan.sv]
// Shared compare unit: keeps the best priority and its slot over a scan.
// Depends on rpts_pkg.
`timescale 1ns / 1ps
module rpts_scan #(
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          step,
	input  logic [SW-1:0] idx,
	input  logic [6:0]    prio,
	input  logic          eligible,
	output logic [SW-1:0] pick
);

	logic [6:0]    best_q;
	logic [SW-1:0] pick_q;
	logic          take;

	// A strict compare keeps the first slot on ties.
	assign take = step && eligible && (prio < best_q);
	assign pick = pick_q;

	// Best-so-far registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= rpts_pkg::PRIO_NONE;
			pick_q <= '0;
		end else if (clear) begin
			best_q <= rpts_pkg::PRIO_NONE;
			pick_q <= '0;
		end else if (take) begin
			best_q <= prio;
			pick_q <= idx;
		end
	end

endmodule

[rtl/rtos_priority_task_scheduler.sv]
// Kernel-call coprocessor: each command passes through fetch, execute and done steps, and
// its result is held in the output register. A scheduler pass adds a clear step, a scan of
// every used task slot and a finish step; a tick scans the used slots above the idle slot,
// and a post scans the same slots and then adds a finish step.
// One command at a time; a stalled result holds the block in its last step until taken.
// Reset (arst_n low) leaves the idle task alone; semaphore counts are undefined until created.
`timescale 1ns / 1ps
module rtos_priority_task_scheduler #(
	parameter int TASK_SLOTS = 8,
	parameter int SEM_SLOTS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [6:0]  task_priority,
	input  logic [15:0] delay_ticks,
	input  logic [2:0]  sem_index,
	input  logic signed [15:0] sem_initial,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  run_task,
	output logic        switched,
	output logic [3:0]  new_index,
	output logic        error,
	output logic [15:0] tick_total,
	output logic [15:0] switch_total
);

	localparam int NSLOT = TASK_SLOTS + 1;
	localparam int SW    = $clog2(NSLOT);
	localparam int CW    = $clog2(NSLOT + 1);
	localparam int SEMW  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
	localparam int AW    = $clog2(SEM_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_EXEC, S_TICK, S_POST, S_POST_FIN,
		S_SCHED, S_SCAN, S_SCAN_FIN, S_DONE
	} state_t;

	state_t state_q;

	// Latched command.
	logic [3:0]  op_q;
	logic [6:0]  prio_q;
	logic [15:0] dly_q;
	logic [2:0]  sidx_q;
	logic signed [15:0] sinit_q;

	// Task table and kernel state.
	logic [6:0]    prio_tbl_q [NSLOT];
	rpts_pkg::status_t status_q [NSLOT];
	logic [15:0]   delay_q [NSLOT];
	logic          waiting_q [NSLOT];
	logic [2:0]    wsem_q [NSLOT];
	logic [CW-1:0] used_q;
	logic [AW-1:0] alloc_q;
	logic [SW-1:0] running_q;
	logic          kernel_q;
	logic          first_q;
	logic [7:0]    nest_q;
	logic [15:0]   ticks_q;
	logic [15:0]   switches_q;
	logic [SW-1:0] idx_q;
	logic          sw_q;
	logic [3:0]    nidx_q;
	logic          err_q;

	// Semaphore counts and registered read port.
	logic signed [15:0] sem_q [SEM_SLOTS];
	logic signed [15:0] sem_rd_q;
	logic               sem_we;
	logic [SEMW-1:0]    sem_wa;
	logic signed [15:0] sem_wd;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  run_task_q;
	logic        switched_q;
	logic [3:0]  new_index_q;
	logic        error_q;
	logic [15:0] tick_total_q;
	logic [15:0] switch_total_q;

	// Scan unit control.
	logic          scan_clear;
	logic          scan_step;
	logic          scan_ok;
	logic [SW-1:0] pick;
	logic [SW-1:0] last_slot;
	logic          sidx_ok;
	logic          out_free;

	assign last_slot = SW'(used_q - CW'(1));
	assign sidx_ok   = (32'(sidx_q) < SEM_SLOTS);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	// Eligibility for the shared compare: ready tasks, or waiters on the semaphore.
	always_comb begin
		scan_clear = (state_q == S_SCHED) || (state_q == S_FETCH);
		scan_step  = (state_q == S_SCAN) || (state_q == S_POST);
		if (state_q == S_POST)
			scan_ok = waiting_q[idx_q] && (wsem_q[idx_q] == sidx_q);
		else
			scan_ok = (status_q[idx_q] == rpts_pkg::ST_READY);
	end

	rpts_scan #(.SW(SW)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (scan_clear),
		.step     (scan_step),
		.idx      (idx_q),
		.prio     (prio_tbl_q[idx_q]),
		.eligible (scan_ok),
		.pick     (pick)
	);

	// Semaphore write data for create, pend and post, with saturation.
	always_comb begin
		sem_we = 1'b0;
		sem_wa = SEMW'(sidx_q);
		sem_wd = sem_rd_q;
		if (state_q == S_EXEC) begin
			unique case (op_q)
				rpts_pkg::OP_SEM_CREATE: begin
					sem_we = (32'(alloc_q) < SEM_SLOTS);
					sem_wa = SEMW'(alloc_q);
					sem_wd = sinit_q;
				end
				rpts_pkg::OP_PEND: begin
					sem_we = sidx_ok;
					sem_wd = (sem_rd_q == rpts_pkg::SEM_MIN) ? sem_rd_q : sem_rd_q - 16'sd1;
				end
				rpts_pkg::OP_POST: begin
					sem_we = sidx_ok;
					sem_wd = (sem_rd_q == rpts_pkg::SEM_MAX) ? sem_rd_q : sem_rd_q + 16'sd1;
				end
				default: sem_we = 1'b0;
			endcase
		end
	end

	// Semaphore memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (sem_we)
			sem_q[sem_wa] <= sem_wd;
		sem_rd_q <= sem_q[SEMW'(sidx_q)];
	end

	// Command sequencer, task table and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			for (int i = 0; i < NSLOT; i++) begin
				prio_tbl_q[i] <= (i == 0) ? rpts_pkg::PRIO_IDLE : rpts_pkg::PRIO_NONE;
				status_q[i]   <= rpts_pkg::ST_READY;
				delay_q[i]    <= '0;
				waiting_q[i]  <= 1'b0;
				wsem_q[i]     <= '0;
			end
			used_q         <= CW'(1);
			alloc_q        <= '0;
			running_q      <= '0;
			kernel_q       <= 1'b0;
			first_q        <= 1'b1;
			nest_q         <= '0;
			ticks_q        <= '0;
			switches_q     <= '0;
			idx_q          <= '0;
			sw_q           <= 1'b0;
			nidx_q         <= '0;
			err_q          <= 1'b0;
			op_q           <= '0;
			prio_q         <= '0;
			dly_q          <= '0;
			sidx_q         <= '0;
			sinit_q        <= '0;
			out_valid_q    <= 1'b0;
			run_task_q     <= '0;
			switched_q     <= 1'b0;
			new_index_q    <= '0;
			error_q        <= 1'b0;
			tick_total_q   <= '0;
			switch_total_q <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						prio_q  <= task_priority;
						dly_q   <= delay_ticks;
						sidx_q  <= sem_index;
						sinit_q <= sem_initial;
						sw_q    <= 1'b0;
						nidx_q  <= '0;
						err_q   <= 1'b0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_DONE;
					unique case (op_q)
						rpts_pkg::OP_CREATE: begin
							if (used_q == CW'(NSLOT)) begin
								err_q <= 1'b1;
							end else begin
								prio_tbl_q[SW'(used_q)] <= prio_q;
								status_q[SW'(used_q)]   <= rpts_pkg::ST_READY;
								delay_q[SW'(used_q)]    <= '0;
								waiting_q[SW'(used_q)]  <= 1'b0;
								wsem_q[SW'(used_q)]     <= '0;
								nidx_q  <= 4'(used_q);
								used_q  <= used_q + CW'(1);
								state_q <= S_SCHED;
							end
						end
						rpts_pkg::OP_START: begin
							if (!kernel_q && used_q >= CW'(2)) begin
								kernel_q <= 1'b1;
								state_q  <= S_SCHED;
							end
						end
						rpts_pkg::OP_DELAY: begin
							if (dly_q != '0) begin
								delay_q[running_q]  <= dly_q;
								status_q[running_q] <= rpts_pkg::ST_DELAYED;
								state_q <= S_SCHED;
							end
						end
						rpts_pkg::OP_TICK: begin
							ticks_q <= ticks_q + 16'd1;
							idx_q   <= SW'(1);
							if (used_q >= CW'(2))
								state_q <= S_TICK;
						end
						rpts_pkg::OP_ISR_ENTER: nest_q <= nest_q + 8'd1;
						rpts_pkg::OP_ISR_EXIT: begin
							nest_q <= nest_q - 8'd1;
							if (nest_q == 8'd1 && kernel_q && used_q >= CW'(2))
								state_q <= S_SCHED;
						end
						rpts_pkg::OP_SEM_CREATE: begin
							if (32'(alloc_q) < SEM_SLOTS) begin
								nidx_q  <= 4'(alloc_q);
								alloc_q <= alloc_q + AW'(1);
							end else begin
								err_q <= 1'b1;
							end
						end
						rpts_pkg::OP_PEND: begin
							if (sidx_ok && sem_rd_q <= 16'sd0) begin
								status_q[running_q]  <= rpts_pkg::ST_SUSPENDED;
								waiting_q[running_q] <= 1'b1;
								wsem_q[running_q]    <= sidx_q;
								state_q <= S_SCHED;
							end
						end
						rpts_pkg::OP_POST: begin
							idx_q <= SW'(1);
							if (sidx_ok && used_q >= CW'(2))
								state_q <= S_POST;
						end
						default: state_q <= S_DONE;
					endcase
				end
				// Count down delayed tasks one slot per cycle.
				S_TICK: begin
					if (status_q[idx_q] == rpts_pkg::ST_DELAYED) begin
						if (delay_q[idx_q] == 16'd1)
							status_q[idx_q] <= rpts_pkg::ST_READY;
						delay_q[idx_q] <= delay_q[idx_q] - 16'd1;
					end
					idx_q <= idx_q + SW'(1);
					if (idx_q == last_slot)
						state_q <= S_DONE;
				end
				// Find the waiter with the best priority.
				S_POST: begin
					idx_q <= idx_q + SW'(1);
					if (idx_q == last_slot)
						state_q <= S_POST_FIN;
				end
				S_POST_FIN: begin
					state_q <= S_DONE;
					if (pick != '0) begin
						status_q[pick]  <= rpts_pkg::ST_READY;
						waiting_q[pick] <= 1'b0;
						wsem_q[pick]    <= '0;
						if (nest_q == 8'd0)
							state_q <= S_SCHED;
					end
				end
				S_SCHED: begin
					idx_q   <= '0;
					state_q <= kernel_q ? S_SCAN : S_DONE;
				end
				// Pick the ready task with the best priority.
				S_SCAN: begin
					idx_q <= idx_q + SW'(1);
					if (idx_q == last_slot)
						state_q <= S_SCAN_FIN;
				end
				S_SCAN_FIN: begin
					state_q <= S_DONE;
					if (first_q) begin
						first_q   <= 1'b0;
						running_q <= pick;
					end else if (pick != running_q) begin
						switches_q <= switches_q + 16'd1;
						running_q  <= pick;
						sw_q       <= 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						run_task_q     <= 4'(running_q);
						switched_q     <= sw_q;
						new_index_q    <= nidx_q;
						error_q        <= err_q;
						tick_total_q   <= ticks_q;
						switch_total_q <= switches_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign run_task     = run_task_q;
	assign switched     = switched_q;
	assign new_index    = new_index_q;
	assign error        = error_q;
	assign tick_total   = tick_total_q;
	assign switch_total = switch_total_q;

endmodule

[rtl/rpts_checker.sv]
// Port-level assertions for the scheduler, bound onto the top level.
// Depends on rtos_priority_task_scheduler.
`timescale 1ns / 1ps
module rpts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  run_task,
	input logic        switched,
	input logic [3:0]  new_index,
	input logic        error,
	input logic [15:0] switch_total
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(run_task) && $stable(switch_total))
		else $error("stalled result changed");

	// The block is busy right after an input transfer.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// A failed create allocates nothing.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> new_index == 4'd0 && !switched)
		else $error("error with allocation or switch");

	// A switch is counted in the total.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched |-> switch_total != 16'd0 || $past(switch_total) == 16'hffff)
		else $error("switch not counted");

endmodule

bind rtos_priority_task_scheduler rpts_checker u_rpts_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the priority task scheduler coprocessor.
// Depends on rpts_pkg and rtos_priority_task_scheduler; predicts each result in a scoreboard.
`timescale 1ns / 1ps
module testbench;

	localparam int NSLOT = 9;
	localparam int NSEM = 8;

	typedef struct packed {
		logic [3:0]  run_task;
		logic        switched;
		logic [3:0]  new_index;
		logic        error;
		logic [15:0] tick_total;
		logic [15:0] switch_total;
	} sched_result_t;

	// Scoreboard: keeps its own copy of the kernel tables and a queue of expected results.
	class sched_scoreboard;
		bit                used[NSLOT];
		logic [6:0]        prio[NSLOT];
		rpts_pkg::status_t stat[NSLOT];
		logic [15:0]       dly[NSLOT];
		bit                waiting[NSLOT];
		logic [2:0]        wsem[NSLOT];
		int                sem_count[NSEM];
		int                sems_made;
		int                running;
		bit                kernel_on;
		bit                first_pick;
		logic [7:0]        depth;
		logic [15:0]       ticks;
		logic [15:0]       switches;
		sched_result_t     expected_q[$];
		int                errors;

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				used[i] = 0;
				prio[i] = rpts_pkg::PRIO_NONE;
				stat[i] = rpts_pkg::ST_READY;
				dly[i] = 0;
				waiting[i] = 0;
				wsem[i] = 0;
			end
			used[0] = 1;
			prio[0] = rpts_pkg::PRIO_IDLE;
			foreach (sem_count[i]) sem_count[i] = 0;
			sems_made = 0;
			running = 0;
			kernel_on = 0;
			first_pick = 1;
			depth = 0;
			ticks = 0;
			switches = 0;
			errors = 0;
		endfunction

		// Pick the ready task with the lowest priority number; returns 1 on a counted switch.
		function bit dispatch();
			int best;
			int pick;
			best = rpts_pkg::PRIO_NONE;
			pick = 0;
			if (!kernel_on)
				return 0;
			for (int i = 0; i < NSLOT; i++) begin
				if (!used[i])
					break;
				if (prio[i] < best && stat[i] == rpts_pkg::ST_READY) begin
					best = prio[i];
					pick = i;
				end
			end
			if (first_pick) begin
				first_pick = 0;
				running = pick;
				return 0;
			end
			if (pick == running)
				return 0;
			switches = switches + 16'd1;
			running = pick;
			return 1;
		endfunction

		// Apply one accepted command and queue the result it should produce.
		function void note_command(logic [3:0] op, logic [6:0] tprio, logic [15:0] ticks_in,
				logic [2:0] sidx, logic signed [15:0] sinit);
			sched_result_t r;
			int slot;
			int best;
			int pick;
			int c;
			r = '0;
			case (op)
				rpts_pkg::OP_CREATE: begin
					slot = NSLOT;
					for (int i = 0; i < NSLOT; i++)
						if (!used[i]) begin
							slot = i;
							break;
						end
					if (slot == NSLOT) begin
						r.error = 1;
					end else begin
						used[slot] = 1;
						prio[slot] = tprio;
						stat[slot] = rpts_pkg::ST_READY;
						dly[slot] = 0;
						waiting[slot] = 0;
						wsem[slot] = 0;
						r.new_index = 4'(slot);
						r.switched = dispatch();
					end
				end
				rpts_pkg::OP_START: begin
					if (!kernel_on && used[1]) begin
						kernel_on = 1;
						r.switched = dispatch();
					end
				end
				rpts_pkg::OP_DELAY: begin
					if (ticks_in != 0) begin
						dly[running] = ticks_in;
						stat[running] = rpts_pkg::ST_DELAYED;
						r.switched = dispatch();
					end
				end
				rpts_pkg::OP_TICK: begin
					ticks = ticks + 16'd1;
					for (int i = 1; i < NSLOT; i++)
						if (stat[i] == rpts_pkg::ST_DELAYED) begin
							if (dly[i] == 1)
								stat[i] = rpts_pkg::ST_READY;
							dly[i] = dly[i] - 16'd1;
						end
				end
				rpts_pkg::OP_ISR_ENTER: depth = depth + 8'd1;
				rpts_pkg::OP_ISR_EXIT: begin
					depth = depth - 8'd1;
					if (depth == 0 && kernel_on && used[1])
						r.switched = dispatch();
				end
				rpts_pkg::OP_SEM_CREATE: begin
					if (sems_made < NSEM) begin
						sem_count[sems_made] = sinit;
						r.new_index = 4'(sems_made);
						sems_made++;
					end else begin
						r.error = 1;
					end
				end
				rpts_pkg::OP_PEND: begin
					c = sem_count[sidx];
					if (c > -32768)
						sem_count[sidx] = c - 1;
					if (c <= 0) begin
						stat[running] = rpts_pkg::ST_SUSPENDED;
						waiting[running] = 1;
						wsem[running] = sidx;
						r.switched = dispatch();
					end
				end
				rpts_pkg::OP_POST: begin
					best = rpts_pkg::PRIO_NONE;
					pick = 0;
					c = sem_count[sidx];
					for (int i = 1; i < NSLOT; i++) begin
						if (!used[i])
							break;
						if (waiting[i] && wsem[i] == sidx && prio[i] < best) begin
							best = prio[i];
							pick = i;
						end
					end
					if (c < 32767)
						sem_count[sidx] = c + 1;
					if (pick != 0) begin
						stat[pick] = rpts_pkg::ST_READY;
						waiting[pick] = 0;
						wsem[pick] = 0;
						if (depth == 0)
							r.switched = dispatch();
					end
				end
				default: ;
			endcase
			r.run_task = 4'(running);
			r.tick_total = ticks;
			r.switch_total = switches;
			expected_q.push_back(r);
		endfunction

		function void field_check(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one accepted result against the oldest expectation.
		function void check_result(sched_result_t got);
			sched_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual run_task %0d",
					$time, got.run_task);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			field_check("run_task", e.run_task, got.run_task);
			field_check("switched", e.switched, got.switched);
			field_check("new_index", e.new_index, got.new_index);
			field_check("error", e.error, got.error);
			field_check("tick_total", e.tick_total, got.tick_total);
			field_check("switch_total", e.switch_total, got.switch_total);
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic [3:0]         opcode = '0;
	logic [6:0]         task_priority = '0;
	logic [15:0]        delay_ticks = '0;
	logic [2:0]         sem_index = '0;
	logic signed [15:0] sem_initial = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [3:0]         run_task;
	logic               switched;
	logic [3:0]         new_index;
	logic               error;
	logic [15:0]        tick_total;
	logic [15:0]        switch_total;

	sched_scoreboard sb = new();
	bit hold_req = 0;
	int burst_left = 0;

	rtos_priority_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .task_priority(task_priority), .delay_ticks(delay_ticks),
		.sem_index(sem_index), .sem_initial(sem_initial),
		.out_valid(out_valid), .out_stall(out_stall),
		.run_task(run_task), .switched(switched), .new_index(new_index), .error(error),
		.tick_total(tick_total), .switch_total(switch_total)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Receiver: stall mode changes every so often; a requested hold-off stalls for long.
	int rx_phase = 0;
	int rx_mode = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result({run_task, switched, new_index, error, tick_total, switch_total});
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 0;
		end
		if (rx_phase == 0) begin
			rx_phase = $urandom_range(50, 300);
			rx_mode = $urandom_range(0, 2);
		end
		rx_phase--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1;
		end else if (rx_mode == 0)
			out_stall <= 0;
		else if (rx_mode == 1)
			out_stall <= ($urandom_range(0, 2) == 0);
		else
			out_stall <= ($urandom_range(0, 3) != 0);
	end

	// Offer one command and hold it until a transfer takes place.
	task automatic send_cmd(logic [3:0] op, logic [6:0] tprio, logic [15:0] ticks_in,
			logic [2:0] sidx, logic [15:0] sinit);
		in_valid <= 1;
		opcode <= op;
		task_priority <= tprio;
		delay_ticks <= ticks_in;
		sem_index <= sidx;
		sem_initial <= sinit;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(op, tprio, ticks_in, sidx, sinit);
	endtask

	// Sender burst pacing: after a burst, usually drop valid for a random gap.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 20);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random command mix, biased toward well-formed kernel traffic.
	task automatic send_random();
		int pick;
		logic [3:0] op;
		logic [15:0] d;
		logic [2:0] s;
		pick = $urandom_range(0, 99);
		d = 16'($urandom);
		s = (sb.sems_made > 0) ? 3'($urandom_range(0, sb.sems_made - 1)) : 3'd0;
		if (pick < 4) op = rpts_pkg::OP_CREATE;
		else if (pick < 6) op = rpts_pkg::OP_START;
		else if (pick < 20) begin
			op = rpts_pkg::OP_DELAY;
			if ($urandom_range(0, 15) == 0) d = 0;
			else if ($urandom_range(0, 15) != 0) d = 16'($urandom_range(1, 6));
		end else if (pick < 45) op = rpts_pkg::OP_TICK;
		else if (pick < 55)
			op = (sb.depth == 0 || ($urandom_range(0, 1) == 0 && sb.depth < 3)) ?
				rpts_pkg::OP_ISR_ENTER : rpts_pkg::OP_ISR_EXIT;
		else if (pick < 58) op = rpts_pkg::OP_SEM_CREATE;
		else if (pick < 75) op = rpts_pkg::OP_PEND;
		else if (pick < 96) op = rpts_pkg::OP_POST;
		else op = 4'($urandom_range(9, 15));
		send_cmd(op, 7'($urandom), d, s, 16'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: behavior before start, table extremes, saturation, nesting wrap.
		send_cmd(rpts_pkg::OP_DELAY, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_START, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_DELAY, 0, 3, 0, 0);
		send_cmd(rpts_pkg::OP_CREATE, 7'd127, 0, 0, 0);
		send_cmd(rpts_pkg::OP_CREATE, 7'd0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_CREATE, 7'd99, 0, 0, 0);
		send_cmd(rpts_pkg::OP_SEM_CREATE, 0, 0, 0, 16'h8000);
		send_cmd(rpts_pkg::OP_SEM_CREATE, 0, 0, 0, 16'h7fff);
		send_cmd(rpts_pkg::OP_SEM_CREATE, 0, 0, 0, 16'h0000);
		for (int i = 3; i < NSEM; i++)
			send_cmd(rpts_pkg::OP_SEM_CREATE, 0, 0, 0, 16'($urandom_range(0, 3)));
		send_cmd(rpts_pkg::OP_SEM_CREATE, 0, 0, 0, 16'h0005);
		send_cmd(rpts_pkg::OP_START, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_PEND, 0, 0, 3'd1, 0);
		send_cmd(rpts_pkg::OP_POST, 0, 0, 3'd1, 0);
		send_cmd(rpts_pkg::OP_POST, 0, 0, 3'd1, 0);
		send_cmd(rpts_pkg::OP_PEND, 0, 0, 3'd0, 0);
		send_cmd(rpts_pkg::OP_ISR_ENTER, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_POST, 0, 0, 3'd0, 0);
		send_cmd(rpts_pkg::OP_ISR_EXIT, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_DELAY, 0, 16'hffff, 3'd7, 0);
		send_cmd(rpts_pkg::OP_TICK, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_ISR_EXIT, 0, 0, 0, 0);
		send_cmd(rpts_pkg::OP_ISR_ENTER, 0, 0, 0, 0);
		send_cmd(4'd15, 0, 0, 0, 0);
		drain();

		// Random traffic with one long receiver hold-off and one full drain.
		for (int n = 0; n < 800; n++) begin
			if (n == 300)
				hold_req = 1;
			if (n == 550)
				drain();
			send_random();
			pace();
		end
		drain();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[files.f]
rtl/rpts_pkg.sv
rtl/rpts_scan.sv
rtl/rtos_priority_task_scheduler.sv
rtl/rpts_checker.sv
tb/testbench.sv
